### hw/rtl/dcc_pkg.sv
package dcc_pkg;

    localparam int FIELD_W     = 16;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 5;
    localparam int OUT_W       = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // item opcodes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROBOT_RADIUS,
        REG_ARENA_LENGTH,
        REG_ARENA_WIDTH,
        REG_OBSTACLE_COUNT
    } cfg_reg_t;

    // the four walls, visited in this order
    typedef enum logic [1:0] {
        WALL_LEFT,
        WALL_BOTTOM,
        WALL_RIGHT,
        WALL_TOP
    } wall_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALL,
        ST_LOAD,
        ST_WAIT,
        ST_FIN
    } ctl_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_PREP,
        DS_MUL,
        DS_ROOT
    } dist_state_t;

    typedef struct packed {
        logic               cmd;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] pos_x;
        logic [FIELD_W-1:0] pos_y;
        logic [FIELD_W-1:0] obstacle_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] clearance_value;
        logic                    free_flag;
    } out_item_t;

endpackage

### hw/rtl/disc_clearance_checker.sv
// Load item: written to the obstacle table at acceptance; the input does not stall after it.
// Query item: walls, then each of the n active obstacles, into the result register. The serial
// distance unit (digit-serial squares, then one root bit per cycle) handles each obstacle.
// One item at a time; a query result waiting at the output does not block a load item.
// Reset (async, active low) clears control and config; the obstacle table is not cleared.
module disc_clearance_checker #(
    parameter int MAX_OBSTACLES = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_en,
    input  logic [dcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dcc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dcc_pkg::in_item_t                   in_item,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output dcc_pkg::out_item_t                  out_item
);

    localparam int C   = COORD_BITS;
    localparam int CW  = C + 3;                       // signed clearance width
    localparam int EW  = 3 * C;                       // table entry: x, y, radius
    localparam int AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NW  = $clog2(MAX_OBSTACLES + 1);
    localparam int LW  = (NW > dcc_pkg::COUNT_W) ? NW : dcc_pkg::COUNT_W;
    localparam int SCW = 9;                           // slot compare, covers depth 256
    localparam int WW  = (CW > dcc_pkg::OUT_W) ? CW : dcc_pkg::OUT_W;

    localparam logic signed [WW-1:0] SAT_HI = WW'((2 ** (dcc_pkg::OUT_W - 1)) - 1);
    localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

    // ------------------------------------------------------------------
    // Configuration registers, masked to COORD_BITS on write
    // ------------------------------------------------------------------
    logic [C-1:0]                rd_reg, len_reg, wid_reg;
    logic [dcc_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            len_reg   <= C'(16'hFFFF);
            wid_reg   <= C'(16'hFFFF);
            count_reg <= '0;
        end
        else if (cfg_en)
        begin
            case (dcc_pkg::cfg_reg_t'(cfg_index))
                dcc_pkg::REG_ROBOT_RADIUS:   rd_reg    <= C'(cfg_data);
                dcc_pkg::REG_ARENA_LENGTH:   len_reg   <= C'(cfg_data);
                dcc_pkg::REG_ARENA_WIDTH:    wid_reg   <= C'(cfg_data);
                dcc_pkg::REG_OBSTACLE_COUNT: count_reg <= cfg_data[dcc_pkg::COUNT_W-1:0];
                default:                     ;
            endcase
        end
    end

    // active entries: the count, clamped to the table depth
    logic [NW-1:0] lim;
    assign lim = (LW'(count_reg) > LW'(MAX_OBSTACLES)) ? NW'(MAX_OBSTACLES)
                                                       : NW'(count_reg);

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    dcc_pkg::ctl_state_t  state_reg, state_next;
    dcc_pkg::wall_t       wall_reg, wall_next;
    logic [NW-1:0]        obs_reg, obs_next;
    logic                 out_valid_reg, out_valid_next;

    logic [C-1:0]            x_reg, x_next, y_reg, y_next;
    logic [C:0]              xr_reg, xr_next, yr_reg, yr_next;
    logic [C:0]              rsum_reg, rsum_next;
    logic signed [CW-1:0]    min_reg, min_next;
    dcc_pkg::out_item_t      out_item_reg, out_item_next;

    logic                    in_acc;
    logic                    tbl_we;
    logic [EW-1:0]           tbl_wdata, tbl_rdata;
    logic [C-1:0]            ent_x, ent_y, ent_r;
    logic                    dist_start, dist_done;
    logic [C:0]              obs_root;
    logic [C:0]              wall_a, wall_b;
    logic signed [CW-1:0]    wall_term, obs_term;
    logic signed [WW-1:0]    min_wide, min_sat;

    assign in_stall = (state_reg != dcc_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Obstacle table: write on a load item, drop slots beyond the depth
    assign tbl_we    = in_acc && (in_item.cmd == dcc_pkg::CMD_LOAD)
                       && (SCW'(in_item.slot) < SCW'(MAX_OBSTACLES));
    assign tbl_wdata = {C'(in_item.pos_x), C'(in_item.pos_y), C'(in_item.obstacle_radius)};

    // The read address follows obs_next so the entry is ready in ST_LOAD
    dcc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_OBSTACLES)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(in_item.slot)),
        .wdata (tbl_wdata),
        .raddr (obs_next[AW-1:0]),
        .rdata (tbl_rdata)
    );

    assign ent_x = tbl_rdata[EW-1 -: C];
    assign ent_y = tbl_rdata[2*C-1 -: C];
    assign ent_r = tbl_rdata[C-1:0];

    dcc_dist #(
        .COORD_BITS (C)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .px    (x_reg),
        .py    (y_reg),
        .ox    (ent_x),
        .oy    (ent_y),
        .done  (dist_done),
        .root  (obs_root)
    );

    // One wall term per cycle: left x-r, bottom y-r, right L-(x+r), top W-(y+r)
    always_comb
    begin
        case (wall_reg)
            dcc_pkg::WALL_LEFT:
            begin
                wall_a = (C+1)'(x_reg);
                wall_b = (C+1)'(rd_reg);
            end
            dcc_pkg::WALL_BOTTOM:
            begin
                wall_a = (C+1)'(y_reg);
                wall_b = (C+1)'(rd_reg);
            end
            dcc_pkg::WALL_RIGHT:
            begin
                wall_a = (C+1)'(len_reg);
                wall_b = xr_reg;
            end
            dcc_pkg::WALL_TOP:
            begin
                wall_a = (C+1)'(wid_reg);
                wall_b = yr_reg;
            end
            default:
            begin
                wall_a = '0;
                wall_b = '0;
            end
        endcase
    end

    assign wall_term = signed'(CW'(wall_a)) - signed'(CW'(wall_b));
    assign obs_term  = signed'(CW'(obs_root)) - signed'(CW'(rsum_reg));

    // Clamp the running minimum to the result width
    assign min_wide = WW'(min_reg);
    assign min_sat  = (min_wide > SAT_HI) ? SAT_HI :
                      (min_wide < SAT_LO) ? SAT_LO : min_wide;

    always_comb
    begin
        state_next     = state_reg;
        wall_next      = wall_reg;
        obs_next       = obs_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xr_next        = xr_reg;
        yr_next        = yr_reg;
        rsum_next      = rsum_reg;
        min_next       = min_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_start     = 1'b0;
        case (state_reg)
            dcc_pkg::ST_IDLE:
            begin
                // load items finish in the table write; only a query moves on
                if (in_acc && (in_item.cmd == dcc_pkg::CMD_QUERY))
                begin
                    x_next     = C'(in_item.pos_x);
                    y_next     = C'(in_item.pos_y);
                    xr_next    = (C+1)'(C'(in_item.pos_x)) + (C+1)'(rd_reg);
                    yr_next    = (C+1)'(C'(in_item.pos_y)) + (C+1)'(rd_reg);
                    wall_next  = dcc_pkg::WALL_LEFT;
                    state_next = dcc_pkg::ST_WALL;
                end
            end
            dcc_pkg::ST_WALL:
            begin
                if ((wall_reg == dcc_pkg::WALL_LEFT) || (wall_term < min_reg))
                begin
                    min_next = wall_term;
                end
                wall_next = dcc_pkg::wall_t'(wall_reg + 2'd1);
                if (wall_reg == dcc_pkg::WALL_TOP)
                begin
                    obs_next   = '0;
                    state_next = (lim == '0) ? dcc_pkg::ST_FIN : dcc_pkg::ST_LOAD;
                end
            end
            dcc_pkg::ST_LOAD:
            begin
                // entry obs_reg is on the table output: launch the distance
                dist_start = 1'b1;
                rsum_next  = (C+1)'(rd_reg) + (C+1)'(ent_r);
                state_next = dcc_pkg::ST_WAIT;
            end
            dcc_pkg::ST_WAIT:
            begin
                if (dist_done)
                begin
                    if (obs_term < min_reg)
                    begin
                        min_next = obs_term;
                    end
                    obs_next   = NW'(obs_reg + 1'b1);
                    state_next = (obs_next == lim) ? dcc_pkg::ST_FIN : dcc_pkg::ST_LOAD;
                end
            end
            dcc_pkg::ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next.clearance_value = min_sat[dcc_pkg::OUT_W-1:0];
                    out_item_next.free_flag       = !min_reg[CW-1] && (min_reg != '0);
                    out_valid_next                = 1'b1;
                    state_next                    = dcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcc_pkg::ST_IDLE;
            wall_reg      <= dcc_pkg::WALL_LEFT;
            obs_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wall_reg      <= wall_next;
            obs_reg       <= obs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        xr_reg       <= xr_next;
        yr_reg       <= yr_next;
        rsum_reg     <= rsum_next;
        min_reg      <= min_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### hw/rtl/dcc_ram.sv
module dcc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/dcc_dist.sv
// Serial distance unit: radix-4 digit-serial dx*dx + dy*dy, then a
// restoring square root that retires one root bit per cycle.
module dcc_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] px,
    input  logic [COORD_BITS-1:0] py,
    input  logic [COORD_BITS-1:0] ox,
    input  logic [COORD_BITS-1:0] oy,
    output logic                  done,
    output logic [COORD_BITS:0]   root
);

    localparam int C     = COORD_BITS;
    localparam int R     = C + 1;
    localparam int MD    = (C + 1) / 2;
    localparam int MW    = 2 * MD;
    localparam int AW2   = 2 * R;
    localparam int PW    = C + 3;
    localparam int CNT_W = $clog2(R + 1);

    dcc_pkg::dist_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [MW-1:0]  mx_reg, mx_next, my_reg, my_next;
    logic [C-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [C+1:0]   c3x_reg, c3x_next, c3y_reg, c3y_next;
    logic [AW2-1:0] acc_reg, acc_next;
    logic [R:0]     rem_reg, rem_next;
    logic [R-1:0]   q_reg, q_next;

    logic [C-1:0]   dx, dy;
    logic [C+1:0]   pp_x, pp_y;
    logic [PW-1:0]  pp_sum;
    logic [R+2:0]   rem_sh, trial, diff;
    logic           ge;

    function automatic logic [C+1:0] pp_sel(input logic [1:0] d,
                                            input logic [C-1:0] m,
                                            input logic [C+1:0] m3);
        logic [C+1:0] r;
        case (d)
            2'd0:    r = '0;
            2'd1:    r = (C+2)'(m);
            2'd2:    r = (C+2)'(m) << 1;
            2'd3:    r = m3;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign dx = (px > ox) ? px - ox : ox - px;
    assign dy = (py > oy) ? py - oy : oy - py;

    assign pp_x   = pp_sel(mx_reg[MW-1 -: 2], cx_reg, c3x_reg);
    assign pp_y   = pp_sel(my_reg[MW-1 -: 2], cy_reg, c3y_reg);
    assign pp_sum = PW'(pp_x) + PW'(pp_y);

    // bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_reg, acc_reg[AW2-1 -: 2]};
    assign trial  = {1'b0, q_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mx_next    = mx_reg;
        my_next    = my_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        c3x_next   = c3x_reg;
        c3y_next   = c3y_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        case (state_reg)
            dcc_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    mx_next    = MW'(dx);
                    my_next    = MW'(dy);
                    cx_next    = dx;
                    cy_next    = dy;
                    state_next = dcc_pkg::DS_PREP;
                end
            end
            dcc_pkg::DS_PREP:
            begin
                c3x_next   = (C+2)'(cx_reg) + ((C+2)'(cx_reg) << 1);
                c3y_next   = (C+2)'(cy_reg) + ((C+2)'(cy_reg) << 1);
                acc_next   = '0;
                cnt_next   = '0;
                state_next = dcc_pkg::DS_MUL;
            end
            dcc_pkg::DS_MUL:
            begin
                acc_next = (acc_reg << 2) + AW2'(pp_sum);
                mx_next  = mx_reg << 2;
                my_next  = my_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MD - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    q_next     = '0;
                    state_next = dcc_pkg::DS_ROOT;
                end
            end
            dcc_pkg::DS_ROOT:
            begin
                acc_next = acc_reg << 2;
                rem_next = ge ? diff[R:0] : rem_sh[R:0];
                q_next   = {q_reg[R-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(R - 1))
                begin
                    done_next  = 1'b1;
                    state_next = dcc_pkg::DS_IDLE;
                end
            end
            default:
            begin
                state_next = dcc_pkg::DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcc_pkg::DS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        c3x_reg <= c3x_next;
        c3y_reg <= c3y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign root = q_reg;

endmodule

### tb/disc_clearance_checker_tb.sv
`timescale 1ns / 100ps

module disc_clearance_checker_tb;

    // Idle cycles with no item moving on either channel before the run is aborted.
    // The slowest legal wait is one full query behind the long output hold, so
    // this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TABLE_DEPTH    = 16;
    localparam int HOLD_CYCLES    = 1500;
    localparam longint CLEAR_MIN  = -131072;
    localparam longint CLEAR_MAX  = 131071;
    localparam int FW             = dcc_pkg::FIELD_W;
    localparam int SW             = dcc_pkg::SLOT_W;
    localparam int DW             = dcc_pkg::CFG_DATA_W;
    localparam int KW             = dcc_pkg::COUNT_W;

    typedef struct {
        logic [FW-1:0] x;
        logic [FW-1:0] y;
        logic [FW-1:0] r;
    } disc_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_en;
    logic [dcc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [DW-1:0]                   cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    dcc_pkg::in_item_t               in_item;
    logic                            out_valid;
    logic                            out_stall;
    dcc_pkg::out_item_t              out_item;

    // Mirror of the block's registers and obstacle table
    logic [FW-1:0]      robot_r;
    logic [FW-1:0]      arena_len;
    logic [FW-1:0]      arena_wid;
    logic [KW-1:0]      active_cnt;
    disc_t              obstacle_map [TABLE_DEPTH];

    // Clearances still owed by the block, oldest first
    dcc_pkg::out_item_t pending_clearances [$];
    dcc_pkg::out_item_t want_result;

    int error_count;
    int load_count;
    int query_count;
    int results_checked;
    int setting_count;
    int idle_cycles;

    // Idling controls: the sender and receiver each get a switch per phase,
    // and the long output hold is requested through hold_request.
    bit tx_idle_en;
    bit rx_idle_en;
    int hold_request;
    int hold_left;
    int stall_left;
    int run_left;

    disc_clearance_checker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor square root, one result bit per pass of the probe.
    function automatic longint floor_root(input longint v);
        longint root;
        longint probe;
        root  = 0;
        probe = longint'(1) << 40;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint fold_min(input longint a, input longint b);
        return (b < a) ? b : a;
    endfunction

    // Smallest clearance of the robot at the query point: four walls, then
    // every active obstacle, each less the radii involved.
    function automatic dcc_pkg::out_item_t predict_clearance(input dcc_pkg::in_item_t item);
        longint             px;
        longint             py;
        longint             rd;
        longint             dx;
        longint             dy;
        longint             best;
        int                 n;
        dcc_pkg::out_item_t res;
        px   = longint'(item.pos_x);
        py   = longint'(item.pos_y);
        rd   = longint'(robot_r);
        n    = (int'(active_cnt) > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_cnt);
        best = px - rd;
        best = fold_min(best, py - rd);
        best = fold_min(best, longint'(arena_len) - (px + rd));
        best = fold_min(best, longint'(arena_wid) - (py + rd));
        for (int i = 0; i < n; i++)
        begin
            dx = px - longint'(obstacle_map[i].x);
            dy = py - longint'(obstacle_map[i].y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            best = fold_min(best,
                floor_root(dx * dx + dy * dy) - (rd + longint'(obstacle_map[i].r)));
        end
        // Saturate to the 18-bit signed output range
        if (best < CLEAR_MIN) best = CLEAR_MIN;
        if (best > CLEAR_MAX) best = CLEAR_MAX;
        res.clearance_value = best[dcc_pkg::OUT_W-1:0];
        res.free_flag       = (best > 0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // Compare every accepted result against the oldest pending clearance.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_clearances.size() == 0)
            begin
                report_mismatch("result arrived with no query pending");
            end
            else
            begin
                want_result = pending_clearances.pop_front();
                results_checked++;
                if (out_item.clearance_value !== want_result.clearance_value)
                    report_mismatch($sformatf("clearance_value got %0d, wanted %0d",
                        out_item.clearance_value, want_result.clearance_value));
                if (out_item.free_flag !== want_result.free_flag)
                    report_mismatch($sformatf("free_flag got %0b, wanted %0b",
                        out_item.free_flag, want_result.free_flag));
            end
        end
    end

    // Abort when nothing moves on either channel for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold on request
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    // One assignment to out_stall per falling edge; the long hold is counted
    // down here so it runs while the sender keeps offering items.
    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        run_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (run_left > 0)
                begin
                    run_left--;
                end
                else
                begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = rx_idle_en ? pick_gap() : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Offer one item from a falling edge, hold it until accepted, then update
    // the mirror: loads go into the table, queries queue their clearance.
    // Leave in_valid high so a back-to-back item does not drop it.
    task automatic send_item(input dcc_pkg::in_item_t item);
        in_item  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (item.cmd == dcc_pkg::CMD_LOAD)
        begin
            obstacle_map[item.slot].x = item.pos_x;
            obstacle_map[item.slot].y = item.pos_y;
            obstacle_map[item.slot].r = item.obstacle_radius;
            load_count++;
        end
        else
        begin
            pending_clearances.push_back(predict_clearance(item));
            query_count++;
        end
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    task automatic send_paced(input dcc_pkg::in_item_t item);
        send_item(item);
        idle_sender(tx_idle_en ? pick_gap() : 0);
    endtask

    function automatic dcc_pkg::in_item_t make_item(input logic cmd, input int slot,
                                                    input int x, input int y, input int r);
        dcc_pkg::in_item_t item;
        item.cmd             = cmd;
        item.slot            = slot[SW-1:0];
        item.pos_x           = x[FW-1:0];
        item.pos_y           = y[FW-1:0];
        item.obstacle_radius = r[FW-1:0];
        return item;
    endfunction

    // Drop valid and wait until every query has answered; the extra idle
    // stretch after that covers a trailing load.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_clearances.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Leave cfg_en high between back-to-back writes; configure lowers it.
    task automatic write_reg(input dcc_pkg::cfg_reg_t idx, input logic [DW-1:0] value);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        case (idx)
            dcc_pkg::REG_ROBOT_RADIUS:   robot_r    = value;
            dcc_pkg::REG_ARENA_LENGTH:   arena_len  = value;
            dcc_pkg::REG_ARENA_WIDTH:    arena_wid  = value;
            dcc_pkg::REG_OBSTACLE_COUNT: active_cnt = value[KW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int radius, input int length, input int width,
                             input int count);
        wait_idle();
        write_reg(dcc_pkg::REG_ROBOT_RADIUS, radius[DW-1:0]);
        write_reg(dcc_pkg::REG_ARENA_LENGTH, length[DW-1:0]);
        write_reg(dcc_pkg::REG_ARENA_WIDTH, width[DW-1:0]);
        write_reg(dcc_pkg::REG_OBSTACLE_COUNT, DW'(count[KW-1:0]));
        cfg_en <= 1'b0;
        setting_count++;
    endtask

    // Random item; queries mostly land inside the arena, some sit near an
    // obstacle and some anywhere. Slot and radius of a query are noise.
    function automatic dcc_pkg::in_item_t random_item();
        dcc_pkg::in_item_t item;
        int                roll;
        int                pick;
        roll = $urandom_range(0, 99);
        item.slot            = SW'($urandom_range(0, TABLE_DEPTH - 1));
        item.pos_x           = FW'($urandom_range(0, 65535));
        item.pos_y           = FW'($urandom_range(0, 65535));
        item.obstacle_radius = FW'($urandom_range(0, 65535));
        if (roll < 35)
        begin
            item.cmd = dcc_pkg::CMD_LOAD;
            if ($urandom_range(0, 3) != 0)
                item.obstacle_radius = FW'($urandom_range(0, 4096));
        end
        else
        begin
            item.cmd = dcc_pkg::CMD_QUERY;
            if (roll < 80)
            begin
                item.pos_x = FW'($urandom_range(0, int'(arena_len)));
                item.pos_y = FW'($urandom_range(0, int'(arena_wid)));
            end
            else if (roll < 90)
            begin
                pick = $urandom_range(0, TABLE_DEPTH - 1);
                item.pos_x = obstacle_map[pick].x ^ FW'($urandom_range(0, 255));
                item.pos_y = obstacle_map[pick].y ^ FW'($urandom_range(0, 255));
            end
        end
        return item;
    endfunction

    // Register value: an extreme now and then, mostly inside a typical band.
    function automatic int pick_setting(input int typ_lo, input int typ_hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return 65535;
        if (roll < 5)  return $urandom_range(0, 65535);
        return $urandom_range(typ_lo, typ_hi);
    endfunction

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return TABLE_DEPTH;
        if (roll == 2) return 31;
        return $urandom_range(1, 31);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: no radius, full arena, no obstacles. Walls only.
    task automatic test_reset_defaults();
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 0, 0, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 15, 65535, 65535, 65535));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 7, 32768, 100, 1234));
    endtask

    // Loads give no result; write the first four slots with extreme entries.
    task automatic test_load_no_result();
        send_paced(make_item(dcc_pkg::CMD_LOAD, 0, 0, 0, 0));
        send_paced(make_item(dcc_pkg::CMD_LOAD, 1, 65535, 65535, 65535));
        send_paced(make_item(dcc_pkg::CMD_LOAD, 2, 32768, 32768, 256));
        send_paced(make_item(dcc_pkg::CMD_LOAD, 3, 100, 60000, 0));
        wait_idle();
    endtask

    // Obstacle terms: on a centre, farthest distance, exact root, counts 4, 1 and 0.
    task automatic test_obstacle_terms();
        configure(128, 65535, 65535, 4);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 0, 0, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 65535, 0, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 32768, 32768, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 65535, 65535, 0));
        configure(0, 65535, 65535, 1);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 300, 400, 0));
        configure(0, 65535, 65535, 0);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 300, 400, 0));
    endtask

    // Point outside the arena and zero clearance both give free_flag low;
    // the largest radii push the clearance to its most negative value.
    task automatic test_outside_arena();
        configure(0, 1000, 2000, 0);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 5000, 100, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 1000, 2000, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 500, 1000, 0));
        configure(0, 0, 0, 0);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 0, 0, 0));
        configure(65535, 0, 0, 4);
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 0, 0, 0));
        send_paced(make_item(dcc_pkg::CMD_QUERY, 0, 65535, 65535, 0));
    endtask

    // Fill every slot, then check that a count above the table depth is
    // clamped to the depth.
    task automatic test_count_limit();
        configure(512, 65535, 65535, 0);
        for (int s = 0; s < TABLE_DEPTH; s++)
            send_paced(make_item(dcc_pkg::CMD_LOAD, s, $urandom_range(0, 65535),
                                 $urandom_range(0, 65535), $urandom_range(0, 2048)));
        configure(512, 65535, 65535, 31);
        repeat (3) send_paced(random_item());
        configure(512, 65535, 65535, TABLE_DEPTH);
        repeat (3) send_paced(random_item());
    endtask

    // Hold the output for a long stretch while items keep coming, so a result
    // sits unread and the next query backs up into the input.
    task automatic test_backpressure();
        configure(256, 65535, 65535, 2);
        tx_idle_en   = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (20) send_item(random_item());
        tx_idle_en   = 1'b1;
    endtask

    // Random traffic over several register settings, one phase per setting.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            configure(pick_setting(0, 3000), pick_setting(16384, 65535),
                      pick_setting(16384, 65535), pick_count());
            // First phase runs flat out on both sides
            tx_idle_en = (phase != 0) && ($urandom_range(0, 4) != 0);
            rx_idle_en = (phase != 0) && ($urandom_range(0, 4) != 0);
            repeat (180) send_paced(random_item());
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_en          = 1'b0;
        cfg_index       = dcc_pkg::REG_ROBOT_RADIUS;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_item         = '0;
        hold_request    = 0;
        tx_idle_en      = 1'b1;
        rx_idle_en      = 1'b1;
        error_count     = 0;
        load_count      = 0;
        query_count     = 0;
        results_checked = 0;
        setting_count   = 0;
        robot_r         = '0;
        arena_len       = 16'hFFFF;
        arena_wid       = 16'hFFFF;
        active_cnt      = '0;
        for (int s = 0; s < TABLE_DEPTH; s++)
            obstacle_map[s] = '{x: '0, y: '0, r: '0};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_load_no_result();
        test_obstacle_terms();
        test_outside_arena();
        test_count_limit();
        test_backpressure();
        test_random_traffic();

        // Drain, then allow a little longer for any stray result
        in_valid <= 1'b0;
        while (pending_clearances.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Sent %0d loads and %0d queries across %0d register settings;",
                 load_count, query_count, setting_count);
        $display("%0d results checked over wall-only, obstacle, out-of-arena, count clamp %s",
                 results_checked, "and long output hold.");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
